/* rtl/dws_pkg.sv */
package dws_pkg;

    // Table geometry
    localparam int MAX_WINDOWS = 16;
    localparam int TABLE_DEPTH = 2 * MAX_WINDOWS;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W      = 32;

    // Command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration space
    localparam int          ADDR_W            = 3;
    localparam int          DATA_W            = 32;
    localparam logic [0:0]  REG_REPEAT_PERIOD = 1'b0;
    localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd86400;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] current_time;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] duration;
    } in_t;

    typedef struct packed {
        logic valve_on;
        logic turned_on;
        logic table_full;
    } out_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic set_full;
        logic tick_rd;
        logic tick_fire;
        logic srch_rd;
        logic srch_adv;
        logic shift_init;
        logic shift_step;
        logic wr_start;
        logic wr_end;
        logic push;
    } dws_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       count_zero;
        logic       count_full;
        logic       tick_gt;
        logic       srch_more;
        logic       srch_gt;
        logic       shift_done;
    } dws_stat_t;

endpackage

/* rtl/dws_ram.sv */
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/dws_ctrl.sv */
module dws_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_req,
    input  logic                out_free,
    input  dws_pkg::dws_stat_t  stat,
    output dws_pkg::dws_cmd_t   cmd,
    output logic                idle
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK_RD,
        S_TICK_CMP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_WR_START,
        S_WR_END,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.command)
                    dws_pkg::CMD_TICK:
                    begin
                        state_next = stat.count_zero ? S_DONE : S_TICK_RD;
                    end
                    dws_pkg::CMD_INSERT:
                    begin
                        if (stat.count_full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    dws_pkg::CMD_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK_RD:
            begin
                cmd.tick_rd = 1'b1;
                state_next  = S_TICK_CMP;
            end
            S_TICK_CMP:
            begin
                cmd.tick_fire = stat.tick_gt;
                state_next    = S_DONE;
            end
            S_SRCH_RD:
            begin
                if (stat.srch_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.srch_gt)
                begin
                    cmd.srch_adv = 1'b1;
                    state_next   = S_SRCH_RD;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_WR_START;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_WR_START:
            begin
                cmd.wr_start = 1'b1;
                state_next   = S_WR_END;
            end
            S_WR_END:
            begin
                cmd.wr_end = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

/* rtl/dws_datapath.sv */
module dws_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dws_pkg::dws_cmd_t            cmd,
    input  dws_pkg::in_t                 in_data,
    input  logic [dws_pkg::TIME_W-1:0]   period,
    output dws_pkg::dws_stat_t           stat,
    output dws_pkg::out_t                result
);

    dws_pkg::in_t                item_reg;
    logic [dws_pkg::CNT_W-1:0]   count_reg,   count_next;
    logic [dws_pkg::IDX_W-1:0]   next_reg,    next_next;
    logic                        busy_reg,    busy_next;
    logic                        on_reg,      on_next;
    logic                        full_reg,    full_next;
    logic [dws_pkg::CNT_W-1:0]   pos_reg,     pos_next;
    logic [dws_pkg::CNT_W-1:0]   src_reg,     src_next;
    logic                        pend_reg,    pend_next;
    logic [dws_pkg::IDX_W-1:0]   wr_addr_reg, wr_addr_next;

    logic                        ram_we;
    logic [dws_pkg::IDX_W-1:0]   ram_waddr;
    logic [dws_pkg::TIME_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [dws_pkg::IDX_W-1:0]   ram_raddr;
    logic [dws_pkg::TIME_W-1:0]  ram_rdata;
    logic [dws_pkg::CNT_W-1:0]   next_inc;

    dws_ram #(
        .WIDTH (dws_pkg::TIME_W),
        .DEPTH (dws_pkg::TABLE_DEPTH)
    ) u_times (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign next_inc = {1'b0, next_reg} + dws_pkg::CNT_W'(1);

    // Table port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.tick_fire)
        begin
            ram_we    = 1'b1;
            ram_waddr = next_reg;
            ram_wdata = ram_rdata + period;
        end
        else if (cmd.shift_step && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_start)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg[dws_pkg::IDX_W-1:0];
            ram_wdata = item_reg.start_time;
        end
        else if (cmd.wr_end)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg[dws_pkg::IDX_W-1:0] + dws_pkg::IDX_W'(1);
            ram_wdata = item_reg.start_time + item_reg.duration;
        end

        if (cmd.tick_rd)
        begin
            ram_re    = 1'b1;
            ram_raddr = next_reg;
        end
        else if (cmd.srch_rd)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_reg[dws_pkg::IDX_W-1:0];
        end
        else if (cmd.shift_step && (src_reg > pos_reg))
        begin
            ram_re    = 1'b1;
            ram_raddr = src_reg[dws_pkg::IDX_W-1:0] - dws_pkg::IDX_W'(1);
        end
    end

    // Control state update
    always_comb
    begin
        count_next   = count_reg;
        next_next    = next_reg;
        busy_next    = busy_reg;
        on_next      = on_reg;
        full_next    = full_reg;
        pos_next     = pos_reg;
        src_next     = src_reg;
        pend_next    = pend_reg;
        wr_addr_next = wr_addr_reg;

        if (cmd.load)
        begin
            on_next   = 1'b0;
            full_next = 1'b0;
            pos_next  = '0;
            pend_next = 1'b0;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            next_next  = '0;
            busy_next  = 1'b0;
        end
        if (cmd.set_full)
        begin
            full_next = 1'b1;
        end
        if (cmd.tick_fire)
        begin
            busy_next = ~busy_reg;
            on_next   = ~busy_reg;
            next_next = (next_inc == count_reg) ? '0 : next_inc[dws_pkg::IDX_W-1:0];
        end
        if (cmd.srch_adv)
        begin
            pos_next = pos_reg + dws_pkg::CNT_W'(2);
        end
        if (cmd.shift_init)
        begin
            src_next  = count_reg;
            pend_next = 1'b0;
        end
        // Move one entry up by two per cycle; each write stores the registered read data at wr_addr_reg
        if (cmd.shift_step)
        begin
            if (src_reg > pos_reg)
            begin
                src_next     = src_reg - dws_pkg::CNT_W'(1);
                pend_next    = 1'b1;
                wr_addr_next = src_reg[dws_pkg::IDX_W-1:0] + dws_pkg::IDX_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        if (cmd.wr_end)
        begin
            count_next = count_reg + dws_pkg::CNT_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_reg    <= '0;
            busy_reg    <= 1'b0;
            on_reg      <= 1'b0;
            full_reg    <= 1'b0;
            pos_reg     <= '0;
            src_reg     <= '0;
            pend_reg    <= 1'b0;
            wr_addr_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            next_reg    <= next_next;
            busy_reg    <= busy_next;
            on_reg      <= on_next;
            full_reg    <= full_next;
            pos_reg     <= pos_next;
            src_reg     <= src_next;
            pend_reg    <= pend_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    // Status to controller
    assign stat.command    = item_reg.command;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg > dws_pkg::CNT_W'(dws_pkg::TABLE_DEPTH - 2));
    assign stat.tick_gt    = (item_reg.current_time > ram_rdata);
    assign stat.srch_more  = (pos_reg < count_reg);
    assign stat.srch_gt    = (item_reg.start_time > ram_rdata);
    assign stat.shift_done = (src_reg == pos_reg) && !pend_reg;

    assign result.valve_on   = busy_reg;
    assign result.turned_on  = on_reg;
    assign result.table_full = full_reg;

`ifndef SYNTH
    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] == 1'b0)
        else $error("entry count is odd");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dws_pkg::CNT_W'(dws_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || ({1'b0, next_reg} < count_reg))
        else $error("next entry outside stored entries");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("insert position beyond entry count");

    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < count_reg + dws_pkg::CNT_W'(2)))
        else $error("table write beyond new entry count");
`endif

endmodule

/* rtl/daily_window_switch_scheduler_top.sv */
// Channel  | Signals                          | Direction | Meaning
// in       | in_valid, in_stall, in_data      | request   | tick, insert or clear
// out      | out_valid, out_stall, out_data   | result    | output level and flags
// cfg      | psel, penable, pwrite, paddr ... | APB       | repeat_period at 0x0
//
// One request at a time. Clear, empty tick, refused insert and unused command codes pass from dispatch to done;
// a tick reads and compares the next entry. An insert searches pair by pair (read, compare),
// then shifts any later entries up, one entry a cycle, and writes the start and end times.
// The result sits in an output register, so a new request is taken while it stalls;
// that next request then waits in its last state until the register frees up.
// Reset clears count, index and output level; table contents are only read once written.
module daily_window_switch_scheduler_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dws_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output dws_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dws_pkg::ADDR_W-1:0]  paddr,
    input  logic [dws_pkg::DATA_W-1:0]  pwdata,
    output logic [dws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    dws_pkg::dws_cmd_t          cmd;
    dws_pkg::dws_stat_t         stat;
    dws_pkg::out_t              result;
    logic                       idle;
    logic                       out_free;
    logic                       out_valid_reg;
    dws_pkg::out_t              out_reg;
    logic [dws_pkg::TIME_W-1:0] period_reg;
    logic                       reg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[dws_pkg::ADDR_W-1:2] == dws_pkg::REG_REPEAT_PERIOD);
    assign prdata  = reg_sel ? period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= dws_pkg::PERIOD_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            period_reg <= pwdata;
        end
    end

    assign in_stall = !idle;
    assign out_free = !out_valid_reg || !out_stall;

    dws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_req   (in_valid),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    dws_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_data),
        .period  (period_reg),
        .stat    (stat),
        .result  (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 3000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE      = 80;

    // command value the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [dws_pkg::ADDR_W-1:0] PERIOD_ADDR =
        dws_pkg::ADDR_W'(4 * dws_pkg::REG_REPEAT_PERIOD);

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    dws_pkg::in_t               in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    dws_pkg::out_t              out_data;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [dws_pkg::ADDR_W-1:0] paddr     = '0;
    logic [dws_pkg::DATA_W-1:0] pwdata    = '0;
    logic [dws_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    daily_window_switch_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // requests waiting to be sent, and switch results still owed by the block
    dws_pkg::in_t  pending_reqs[$];
    dws_pkg::out_t expected_levels[$];

    // shadow of the schedule table
    logic [dws_pkg::TIME_W-1:0] win_times[dws_pkg::TABLE_DEPTH];
    int unsigned                win_count  = 0;
    int unsigned                win_ptr    = 0;
    logic                       level      = 1'b0;
    logic [dws_pkg::TIME_W-1:0] period_reg = dws_pkg::PERIOD_RESET;

    int   fail_count    = 0;
    int   idle_cycles   = 0;
    int   queued_items  = 0;
    int   send_gap      = 0;
    int   recv_wait     = 0;
    logic sender_calm   = 1'b0;
    logic receiver_calm = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one request to the shadow table and return the result it should produce
    function automatic dws_pkg::out_t predict_request(dws_pkg::in_t req);
        dws_pkg::out_t res;
        int unsigned   idx;
        int unsigned   pos;
        int unsigned   k;
        res = '0;
        case (req.command)
            dws_pkg::CMD_TICK:
            begin
                if (win_count != 0)
                begin
                    idx = win_ptr % win_count;
                    if (req.current_time > win_times[idx])
                    begin
                        win_times[idx] = win_times[idx] + period_reg;
                        win_ptr = (idx + 1) % win_count;
                        level = ~level;
                        res.turned_on = level;
                    end
                end
            end
            dws_pkg::CMD_INSERT:
            begin
                if (win_count + 2 > dws_pkg::TABLE_DEPTH)
                    res.table_full = 1'b1;
                else
                begin
                    pos = 0;
                    while (pos < win_count && req.start_time > win_times[pos])
                        pos += 2;
                    for (k = win_count; k > pos; k--)
                        win_times[k + 1] = win_times[k - 1];
                    win_times[pos] = req.start_time;
                    win_times[pos + 1] = req.start_time + req.duration;
                    win_count += 2;
                end
            end
            dws_pkg::CMD_CLEAR:
            begin
                win_count = 0;
                win_ptr = 0;
                level = 1'b0;
            end
            default: ;
        endcase
        res.valve_on = level;
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %0h, actual %0h at %0t",
                     what, want_v, got_v, $realtime);
    endtask

    function automatic void push_req(logic [1:0] cmd, logic [31:0] now,
                                     logic [31:0] st, logic [31:0] dur);
        dws_pkg::in_t r;
        r.command = cmd;
        r.current_time = now;
        r.start_time = st;
        r.duration = dur;
        pending_reqs.push_back(r);
        if (cmd != CMD_UNUSED)
            queued_items++;
    endfunction

    // A well-formed run: optional clear, a batch of windows near one base time,
    // then ticks with a rising clock that walk through them, with an occasional insert
    task automatic queue_scenario();
        logic [31:0] base;
        logic [31:0] now;
        int          n_win;
        int          n_tick;
        base = $urandom();
        if ($urandom_range(0, 3) != 0)
            push_req(dws_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
        n_win = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
        for (int i = 0; i < n_win; i++)
            push_req(dws_pkg::CMD_INSERT, $urandom(), base + $urandom_range(0, 2000),
                     ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 300));
        n_tick = $urandom_range(2, 3 * n_win + 4);
        now = base;
        for (int i = 0; i < n_tick; i++)
        begin
            now = now + $urandom_range(0, 200);
            if ($urandom_range(0, 19) == 0)
                push_req(dws_pkg::CMD_INSERT, $urandom(), now + $urandom_range(0, 500),
                         $urandom_range(0, 300));
            push_req(dws_pkg::CMD_TICK, now, $urandom(), $urandom());
        end
    endtask

    // Wait until nothing is in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_levels.size() != 0);
    endtask

    // Write the repeat period and read it back
    task automatic set_period(logic [dws_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PERIOD_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        period_reg = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== period_reg)
            note_mismatch("repeat_period readback", period_reg, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        int g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            g = send_gap;
            if (in_valid && !in_stall)
            begin
                expected_levels.push_back(predict_request(in_data));
                if ($urandom_range(0, 31) == 0)
                    sender_calm = ~sender_calm;
                g = sender_calm ? 0 : $urandom_range(0, 18);
            end
            // a stalled request holds its payload
            if (!(in_valid && in_stall))
            begin
                if (g != 0 || pending_reqs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= (g != 0) ? g - 1 : 0;
                end
                else
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= 0;
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin : watch
        int            w;
        dws_pkg::out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            w = (recv_wait > 0) ? recv_wait - 1 : 0;
            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                    note_mismatch("result with nothing expected", '0, 32'(out_data));
                else
                begin
                    want = expected_levels.pop_front();
                    if (out_data.valve_on !== want.valve_on)
                        note_mismatch("valve_on", 32'(want.valve_on),
                                      32'(out_data.valve_on));
                    if (out_data.turned_on !== want.turned_on)
                        note_mismatch("turned_on", 32'(want.turned_on),
                                      32'(out_data.turned_on));
                    if (out_data.table_full !== want.table_full)
                        note_mismatch("table_full", 32'(want.table_full),
                                      32'(out_data.table_full));
                end
                if ($urandom_range(0, 31) == 0)
                    receiver_calm = ~receiver_calm;
                w = receiver_calm ? 0 : $urandom_range(0, 18);
            end
            recv_wait <= w;
            out_stall <= (w != 0);
        end
    end

    // Cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        logic [31:0] p;
        int          target;
        for (int i = 0; i < dws_pkg::TABLE_DEPTH; i++)
            win_times[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, equal start, ignored command,
        // insert while running, full table, clear while on
        push_req(dws_pkg::CMD_TICK, 32'hFFFF_FFFF, '0, '0);
        push_req(CMD_UNUSED, $urandom(), $urandom(), $urandom());
        push_req(dws_pkg::CMD_INSERT, '0, 32'd0, 32'd0);
        push_req(dws_pkg::CMD_INSERT, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(dws_pkg::CMD_INSERT, '0, 32'd1000, 32'd500);
        push_req(dws_pkg::CMD_INSERT, '0, 32'd1000, 32'd10);
        push_req(dws_pkg::CMD_TICK, 32'd0, '0, '0);
        push_req(dws_pkg::CMD_TICK, 32'd1, '0, '0);
        push_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(dws_pkg::CMD_TICK, 32'hFFFF_FFFF, '0, '0);
        push_req(dws_pkg::CMD_INSERT, '0, 32'd5, 32'd5);
        for (int i = 0; i < 11; i++)
            push_req(dws_pkg::CMD_INSERT, $urandom(), $urandom(), $urandom());
        push_req(dws_pkg::CMD_INSERT, '0, 32'd7, 32'd7);
        push_req(dws_pkg::CMD_TICK, 32'hFFFF_FFFF, '0, '0);
        push_req(dws_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(dws_pkg::CMD_TICK, 32'hFFFF_FFFF, '0, '0);
        wait_drained();

        // random phases, each under its own repeat period
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: p = 32'd1;
                1: p = 32'hFFFF_FFFF;
                2: p = dws_pkg::PERIOD_RESET;
                3: p = $urandom_range(2, 5000);
                default: p = $urandom() | 32'd1;
            endcase
            set_period(p);
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 5))
                        push_req(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                                 $urandom());
                end
                else
                    queue_scenario();
            end
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && expected_levels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dws_pkg.sv
rtl/dws_ram.sv
rtl/dws_ctrl.sv
rtl/dws_datapath.sv
rtl/daily_window_switch_scheduler_top.sv
test/tb.sv
